FILE: rtl/core/tile_wall_outline_renderer_top_assert.svh
// Assertion macros for the tile wall outline renderer.
`ifndef TILE_WALL_OUTLINE_RENDERER_TOP_ASSERT_SVH
`define TILE_WALL_OUTLINE_RENDERER_TOP_ASSERT_SVH

// Checked on every rising edge, off while reset is asserted.
`define TWOR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("twor: assertion failed");

// Checked on every rising edge, reset included.
`define TWOR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("twor: assertion failed");

`endif

FILE: rtl/core/twor_pkg.sv
// Package of the tile wall outline renderer: constants and the outline function.
`default_nettype none

package twor_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 32;
  localparam int unsigned MAX_ROWS_DEF    = 32;

  localparam int unsigned COORD_W = 5;
  localparam int unsigned GRID_W  = 6;
  localparam int unsigned CMP_W   = 10;
  localparam int unsigned MASK_W  = 64;

  localparam logic [GRID_W-1:0] GRID_RESET = 6'd32;

  typedef enum logic [0:0] {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  function automatic logic [5:0] pix(input int unsigned x, input int unsigned y);
    return 6'(y * 8 + x);
  endfunction

  function automatic logic [MASK_W-1:0] outline(
    input logic tl, input logic t,  input logic tr,
    input logic l,  input logic rr,
    input logic bl, input logic b,  input logic br
  );
    logic [MASK_W-1:0] m;
    m = '0;
    // top side
    if (t) begin
      if (!(tl && l)) begin
        m[pix(2, 0)] = 1'b1;
        m[pix(2, 1)] = 1'b1;
      end
      if (!l) m[pix(2, 2)] = 1'b1;
      if (!(tr && rr)) begin
        m[pix(5, 0)] = 1'b1;
        m[pix(5, 1)] = 1'b1;
      end
      if (!rr) m[pix(5, 2)] = 1'b1;
    end else begin
      m[pix(3, 2)] = 1'b1;
      m[pix(4, 2)] = 1'b1;
    end
    // left side
    if (l) begin
      if (!(tl && t)) begin
        m[pix(0, 2)] = 1'b1;
        m[pix(1, 2)] = 1'b1;
      end
      if (!t) m[pix(2, 2)] = 1'b1;
      if (!(bl && b)) begin
        m[pix(0, 5)] = 1'b1;
        m[pix(1, 5)] = 1'b1;
      end
      if (!b) m[pix(2, 5)] = 1'b1;
    end else begin
      m[pix(2, 3)] = 1'b1;
      m[pix(2, 4)] = 1'b1;
    end
    // bottom side
    if (b) begin
      if (!(bl && l)) begin
        m[pix(2, 6)] = 1'b1;
        m[pix(2, 7)] = 1'b1;
      end
      if (!l) m[pix(2, 5)] = 1'b1;
      if (!(br && rr)) begin
        m[pix(5, 6)] = 1'b1;
        m[pix(5, 7)] = 1'b1;
      end
      if (!rr) m[pix(5, 5)] = 1'b1;
    end else begin
      m[pix(3, 5)] = 1'b1;
      m[pix(4, 5)] = 1'b1;
    end
    // right side
    if (rr) begin
      if (!(tr && t)) begin
        m[pix(6, 2)] = 1'b1;
        m[pix(7, 2)] = 1'b1;
      end
      if (!t) m[pix(5, 2)] = 1'b1;
      if (!(br && b)) begin
        m[pix(6, 5)] = 1'b1;
        m[pix(7, 5)] = 1'b1;
      end
      if (!b) m[pix(5, 5)] = 1'b1;
    end else begin
      m[pix(5, 3)] = 1'b1;
      m[pix(5, 4)] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tile_wall_outline_renderer_top.sv
// Top level of the tile wall outline renderer: wall map memory, control and output stage.
`default_nettype none

// The block keeps a one-bit wall map of MAX_COLUMNS x MAX_ROWS tiles, one memory
// word per tile row, and answers render requests with the 8x8 outline mask of a
// tile. On acceptance of a request the map rows above, at and below the tile are
// read from three identical copies of the row memory, and in the next cycle the
// neighbourhood is decoded into the mask (render) or the row word is modified and
// written back to all copies (write). The row memory read is registered. Results
// wait in an output register; a stalled output holds a finished render in the
// S_RENDER state, where no new request is accepted. Reset needs no clearing pass:
// per-row valid flags make unwritten rows read as non-wall.
module tile_wall_outline_renderer_top #(
  parameter int unsigned MAX_COLUMNS = twor_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = twor_pkg::MAX_ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // tile_column[4:0], tile_row[9:5], wall_bit[10]
  input  wire logic [0:0]  s_axis_tuser_i,  // operation[0]
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o   // pixel_mask[63:0], out_of_grid[64]
);

  localparam int unsigned CW   = $clog2(MAX_COLUMNS);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned CMPW = twor_pkg::CMP_W;
  localparam int unsigned GW   = twor_pkg::GRID_W;
  localparam int unsigned XW   = twor_pkg::COORD_W;

  localparam logic [CMPW-1:0] MaxCols = CMPW'(MAX_COLUMNS);
  localparam logic [CMPW-1:0] MaxRows = CMPW'(MAX_ROWS);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RENDER = 3'b010,
    S_WRITE  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [GW-1:0] grid_cols_q, grid_rows_q;

  logic [MAX_COLUMNS-1:0] mem0 [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] mem1 [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] mem2 [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rd0_q, rd1_q, rd2_q;
  logic [MAX_ROWS-1:0]    row_valid_q;
  logic [2:0]             rv_q;

  logic [XW-1:0] col_q, row_q;
  logic          wall_q, wr_ok_q;

  logic           in_acc, load_out, mem_we, rd_en;
  logic [XW-1:0]  in_col, in_row;
  logic [CMPW-1:0] in_col_ext, in_row_ext, a0, a1, a2;
  logic [RW-1:0]  addr0, addr1, addr2, wr_addr;
  logic [CW-1:0]  wr_col;
  logic [MAX_COLUMNS-1:0] wr_word;

  logic [CMPW-1:0] col_ext, row_ext, grid_c_ext, grid_r_ext;
  logic            in_grid, cm_ok, cp_ok, rm_ok, rp_ok;
  logic [MAX_COLUMNS+1:0] sh0, sh1, sh2;
  logic [MAX_COLUMNS-1:0] w0, w1, w2;
  logic            tl, t, tr, l, c, rr, bl, b, br;
  logic [63:0]     mask;

  logic        out_valid_q;
  logic [71:0] out_data_q;

  // config
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= twor_pkg::GRID_RESET;
      grid_rows_q <= twor_pkg::GRID_RESET;
    end else if (cfg_valid_i) begin
      unique case (twor_pkg::reg_idx_e'(cfg_index_i))
        twor_pkg::REG_GRID_COLUMNS: grid_cols_q <= cfg_data_i;
        twor_pkg::REG_GRID_ROWS:    grid_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request side
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_en      = in_acc;
  assign in_col     = s_axis_tdata_i[4:0];
  assign in_row     = s_axis_tdata_i[9:5];
  assign in_col_ext = CMPW'(in_col);
  assign in_row_ext = CMPW'(in_row);

  always_comb begin
    a0 = in_row_ext - CMPW'(1);
    a1 = in_row_ext;
    a2 = in_row_ext + CMPW'(1);
    if (a0 >= MaxRows) a0 = '0;
    if (a1 >= MaxRows) a1 = '0;
    if (a2 >= MaxRows) a2 = '0;
    addr0 = a0[RW-1:0];
    addr1 = a1[RW-1:0];
    addr2 = a2[RW-1:0];
  end

  // row memories, one copy per read port
  assign mem_we  = (state_q == S_WRITE) && wr_ok_q;
  assign wr_addr = row_ext[RW-1:0];
  assign wr_col  = col_ext[CW-1:0];

  always_comb begin
    wr_word = rv_q[1] ? rd1_q : '0;
    wr_word[wr_col] = wall_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem0[wr_addr] <= wr_word;
    if (rd_en)  rd0_q <= mem0[addr0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem1[wr_addr] <= wr_word;
    if (rd_en)  rd1_q <= mem1[addr1];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem2[wr_addr] <= wr_word;
    if (rd_en)  rd2_q <= mem2[addr2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (mem_we) begin
      row_valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rv_q    <= {row_valid_q[addr2], row_valid_q[addr1], row_valid_q[addr0]};
      col_q   <= in_col;
      row_q   <= in_row;
      wall_q  <= s_axis_tdata_i[10];
      wr_ok_q <= (in_col_ext < MaxCols) && (in_row_ext < MaxRows);
    end
  end

  // neighbourhood decode
  assign col_ext    = CMPW'(col_q);
  assign row_ext    = CMPW'(row_q);
  assign grid_c_ext = CMPW'(grid_cols_q);
  assign grid_r_ext = CMPW'(grid_rows_q);

  assign in_grid = (col_ext < grid_c_ext) && (col_ext < MaxCols)
                && (row_ext < grid_r_ext) && (row_ext < MaxRows);
  assign cm_ok   = (col_q != '0);
  assign rm_ok   = (row_q != '0);
  assign cp_ok   = ((col_ext + CMPW'(1)) < grid_c_ext) && ((col_ext + CMPW'(1)) < MaxCols);
  assign rp_ok   = ((row_ext + CMPW'(1)) < grid_r_ext) && ((row_ext + CMPW'(1)) < MaxRows);

  assign w0 = (rv_q[0] && rm_ok) ? rd0_q : '0;
  assign w1 = rv_q[1] ? rd1_q : '0;
  assign w2 = (rv_q[2] && rp_ok) ? rd2_q : '0;

  // bit 0 of each shifted word is column c-1, bit 1 column c, bit 2 column c+1
  assign sh0 = {1'b0, w0, 1'b0} >> col_q;
  assign sh1 = {1'b0, w1, 1'b0} >> col_q;
  assign sh2 = {1'b0, w2, 1'b0} >> col_q;

  assign tl = sh0[0] && cm_ok;
  assign t  = sh0[1];
  assign tr = sh0[2] && cp_ok;
  assign l  = sh1[0] && cm_ok;
  assign c  = sh1[1];
  assign rr = sh1[2] && cp_ok;
  assign bl = sh2[0] && cm_ok;
  assign b  = sh2[1];
  assign br = sh2[2] && cp_ok;

  assign mask = (in_grid && c) ? twor_pkg::outline(tl, t, tr, l, rr, bl, b, br) : '0;

  // control
  assign load_out = (state_q == S_RENDER) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (twor_pkg::op_e'(s_axis_tuser_i[0]) == twor_pkg::OP_RENDER)
                  ? S_RENDER : S_WRITE;
        end
      end
      S_RENDER: begin
        if (load_out) state_d = S_IDLE;
      end
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_data_q <= {7'b0, !in_grid, mask};
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `include "tile_wall_outline_renderer_top_assert.svh"

  `TWOR_ASSERT(a_busy_after_accept, in_acc |=> !s_axis_tready_o)
  `TWOR_ASSERT(a_oog_mask_zero,
               m_axis_tvalid_o |-> (!m_axis_tdata_o[64] || (m_axis_tdata_o[63:0] == '0)))
  `TWOR_ASSERT(a_write_no_result,
               (in_acc && !s_axis_tuser_i[0]) |=> !$rose(m_axis_tvalid_o))
  `TWOR_ASSERT(a_render_result,
               (in_acc && s_axis_tuser_i[0] && !m_axis_tvalid_o) |=> ##1 m_axis_tvalid_o)

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the tile wall outline renderer: scoreboard, drivers and run control.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [63:0] mask;
    logic        oog;
  } tile_result_t;

  class tile_mask_predictor;
    logic [31:0]  wall_rows [32];
    logic [5:0]   columns_reg;
    logic [5:0]   rows_reg;
    tile_result_t masks_due [$];
    int           mismatches;
    int           renders_checked;
    int           oog_checked;
    int           writes_seen;
    int           regs_written;

    function void clear();
      foreach (wall_rows[i]) wall_rows[i] = '0;
      columns_reg     = twor_pkg::GRID_RESET;
      rows_reg        = twor_pkg::GRID_RESET;
      masks_due.delete();
      mismatches      = 0;
      renders_checked = 0;
      oog_checked     = 0;
      writes_seen     = 0;
      regs_written    = 0;
    endfunction

    function void take_reg(twor_pkg::reg_idx_e idx, logic [5:0] value);
      if (idx == twor_pkg::REG_GRID_COLUMNS) columns_reg = value;
      else rows_reg = value;
      regs_written++;
    endfunction

    function int used_columns();
      return (columns_reg > 32) ? 32 : int'(columns_reg);
    endfunction

    function int used_rows();
      return (rows_reg > 32) ? 32 : int'(rows_reg);
    endfunction

    function bit wall_at(int c, int r);
      if (c < 0 || r < 0) return 1'b0;
      if (c >= used_columns() || r >= used_rows()) return 1'b0;
      return wall_rows[r][c];
    endfunction

    function logic [63:0] dot(int x, int y);
      return 64'd1 << (y * 8 + x);
    endfunction

    function logic [63:0] column_line(int x, int o0, int o1, int yi, bit diag, bit flank);
      logic [63:0] m;
      m = '0;
      if (!(diag && flank)) m |= dot(x, o0) | dot(x, o1);
      if (!flank) m |= dot(x, yi);
      return m;
    endfunction

    function logic [63:0] row_line(int y, int o0, int o1, int xi, bit diag, bit flank);
      logic [63:0] m;
      m = '0;
      if (!(diag && flank)) m |= dot(o0, y) | dot(o1, y);
      if (!flank) m |= dot(xi, y);
      return m;
    endfunction

    function logic [63:0] tile_mask(int c, int r);
      bit nw, n, ne, w, e, sw, s, se;
      logic [63:0] m;
      nw = wall_at(c - 1, r - 1);
      n  = wall_at(c, r - 1);
      ne = wall_at(c + 1, r - 1);
      w  = wall_at(c - 1, r);
      e  = wall_at(c + 1, r);
      sw = wall_at(c - 1, r + 1);
      s  = wall_at(c, r + 1);
      se = wall_at(c + 1, r + 1);
      m  = '0;
      if (!wall_at(c, r)) return m;
      if (n) m |= column_line(2, 0, 1, 2, nw, w) | column_line(5, 0, 1, 2, ne, e);
      else m |= dot(3, 2) | dot(4, 2);
      if (w) m |= row_line(2, 0, 1, 2, nw, n) | row_line(5, 0, 1, 2, sw, s);
      else m |= dot(2, 3) | dot(2, 4);
      if (s) m |= column_line(2, 6, 7, 5, sw, w) | column_line(5, 6, 7, 5, se, e);
      else m |= dot(3, 5) | dot(4, 5);
      if (e) m |= row_line(2, 6, 7, 5, ne, n) | row_line(5, 6, 7, 5, se, s);
      else m |= dot(5, 3) | dot(5, 4);
      return m;
    endfunction

    function void take_request(twor_pkg::op_e op, logic [4:0] col, logic [4:0] row,
                               logic wall);
      tile_result_t res;
      if (op == twor_pkg::OP_WRITE) begin
        wall_rows[row][col] = wall;
        writes_seen++;
        return;
      end
      if (int'(col) >= used_columns() || int'(row) >= used_rows()) begin
        res.mask = '0;
        res.oog  = 1'b1;
      end else begin
        res.mask = tile_mask(int'(col), int'(row));
        res.oog  = 1'b0;
      end
      masks_due = {masks_due, res};
    endfunction

    function void match_mask(logic [63:0] mask, logic oog);
      tile_result_t want;
      if (masks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result mask %h oog %0b", $time, mask, oog);
        return;
      end
      want = masks_due.pop_front();
      renders_checked++;
      if (want.oog) oog_checked++;
      if (mask !== want.mask || oog !== want.oog) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected mask %h oog %0b, got mask %h oog %0b",
                   $time, want.mask, want.oog, mask, oog);
      end
    endfunction

    function int outstanding();
      return masks_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [5:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic [0:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;

  tile_mask_predictor tracker;
  bit steady;
  bit hold_off_req;
  int hold_count;
  int sent_count;

  tile_wall_outline_renderer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // monitor: requests, register writes and results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        tracker.take_reg(twor_pkg::reg_idx_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o)
        tracker.take_request(twor_pkg::op_e'(s_axis_tuser_i[0]), s_axis_tdata_i[4:0],
                             s_axis_tdata_i[9:5], s_axis_tdata_i[10]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracker.match_mask(m_axis_tdata_o[63:0], m_axis_tdata_o[64]);
    end
  end

  // result sink with random stalls and one long hold-off on request
  initial begin
    int stall_left;
    int n;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready_i = 1'b0;
        for (n = 0; n < 300; n++) @(negedge clk_i);
        hold_off_req = 1'b0;
        hold_count++;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i = 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  task automatic send_request(twor_pkg::op_e op, logic [4:0] col, logic [4:0] row,
                              logic wall);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {5'b0, wall, row, col};
    s_axis_tuser_i  = op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_count++;
  endtask

  task automatic stream_pause();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain_results();
    stream_pause();
    while (tracker.outstanding() != 0) @(posedge clk_i);
    // a trailing write may still be in flight
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_reg(twor_pkg::reg_idx_e idx, logic [5:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_grid(logic [5:0] cols, logic [5:0] rows);
    drain_results();
    program_reg(twor_pkg::REG_GRID_COLUMNS, cols);
    program_reg(twor_pkg::REG_GRID_ROWS, rows);
  endtask

  task automatic random_burst();
    int uc, ur, n_wr, n_rd, k;
    logic [4:0] bc, br;
    if ($urandom_range(0, 99) < 15) begin
      for (k = 0; k < 4; k++)
        send_request(twor_pkg::op_e'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      return;
    end
    uc = tracker.used_columns();
    ur = tracker.used_rows();
    bc = (uc == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, uc - 1));
    br = (ur == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, ur - 1));
    n_wr = $urandom_range(3, 8);
    n_rd = $urandom_range(2, 5);
    for (k = 0; k < n_wr; k++)
      send_request(twor_pkg::OP_WRITE, bc + 5'($urandom_range(0, 3)) - 5'd1,
                   br + 5'($urandom_range(0, 3)) - 5'd1, ($urandom_range(0, 2) != 0));
    for (k = 0; k < n_rd; k++)
      send_request(twor_pkg::OP_RENDER, bc + 5'($urandom_range(0, 3)) - 5'd1,
                   br + 5'($urandom_range(0, 3)) - 5'd1, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int phase_cols [10];
    int phase_rows [10];
    int p, stop_at;
    tracker = new();
    tracker.clear();
    steady          = 1'b0;
    hold_off_req    = 1'b0;
    hold_count      = 0;
    sent_count      = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = twor_pkg::REG_GRID_COLUMNS;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = twor_pkg::OP_WRITE;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset grid, corners and full neighborhoods
    send_request(twor_pkg::OP_RENDER, 5'd0, 5'd0, 1'b0);
    send_request(twor_pkg::OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_request(twor_pkg::OP_RENDER, 5'd0, 5'd0, 1'b1);
    send_request(twor_pkg::OP_WRITE, 5'd1, 5'd0, 1'b1);
    send_request(twor_pkg::OP_WRITE, 5'd0, 5'd1, 1'b1);
    send_request(twor_pkg::OP_WRITE, 5'd1, 5'd1, 1'b1);
    send_request(twor_pkg::OP_RENDER, 5'd0, 5'd0, 1'b0);
    send_request(twor_pkg::OP_RENDER, 5'd1, 5'd1, 1'b0);
    send_request(twor_pkg::OP_WRITE, 5'd31, 5'd31, 1'b1);
    send_request(twor_pkg::OP_WRITE, 5'd30, 5'd31, 1'b1);
    send_request(twor_pkg::OP_RENDER, 5'd31, 5'd31, 1'b0);
    // one column, rows saturated; write outside grid is stored but unseen
    set_grid(6'd1, 6'd63);
    send_request(twor_pkg::OP_RENDER, 5'd1, 5'd0, 1'b0);
    send_request(twor_pkg::OP_RENDER, 5'd0, 5'd0, 1'b0);
    send_request(twor_pkg::OP_WRITE, 5'd3, 5'd5, 1'b1);
    send_request(twor_pkg::OP_RENDER, 5'd0, 5'd31, 1'b0);
    // empty grid
    set_grid(6'd0, 6'd0);
    send_request(twor_pkg::OP_RENDER, 5'd0, 5'd0, 1'b0);
    send_request(twor_pkg::OP_WRITE, 5'd3, 5'd4, 1'b1);
    // columns saturated: earlier writes become visible
    set_grid(6'd63, 6'd32);
    send_request(twor_pkg::OP_RENDER, 5'd3, 5'd5, 1'b0);
    send_request(twor_pkg::OP_RENDER, 5'd3, 5'd4, 1'b0);
    send_request(twor_pkg::OP_WRITE, 5'd0, 5'd0, 1'b0);
    send_request(twor_pkg::OP_RENDER, 5'd0, 5'd0, 1'b0);
    send_request(twor_pkg::OP_RENDER, 5'd1, 5'd1, 1'b0);

    phase_cols = '{32, 4, 63, 1, 32, 33, 0, 2, 20, 0};
    phase_rows = '{32, 6, 63, 32, 1, 40, 17, 2, 9, 0};
    phase_cols[9] = $urandom_range(1, 63);
    phase_rows[9] = $urandom_range(1, 63);
    for (p = 0; p < 10; p++) begin
      set_grid(6'(phase_cols[p]), 6'(phase_rows[p]));
      steady  = (p == 4);
      stop_at = sent_count + 60;
      if (p == 1) hold_off_req = 1'b1;
      while (sent_count < stop_at) begin
        random_burst();
        if (p == 6 && sent_count > stop_at - 30 && sent_count < stop_at - 20)
          drain_results();
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d requests (%0d writes), %0d renders checked, %0d out of grid.",
             sent_count, tracker.writes_seen, tracker.renders_checked, tracker.oog_checked);
    $display("%0d register writes over 13 grid settings, %0d long output hold-offs.",
             tracker.regs_written, hold_count);
    if (tracker.outstanding() != 0)
      $display("%0d expected results never arrived", tracker.outstanding());
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

endmodule
